/* sv/sha256_pkg.sv */
// Shared types, codes and constants for the SHA-256 stream hasher.
// No dependencies; imported by the controller, the datapath and the top level.
package sha256_pkg;

  localparam int WordW   = 32;
  localparam int RoundsN = 64;

  typedef enum logic [1:0] {
    FUNC_ABSORB = 2'd0,
    FUNC_FINAL  = 2'd1,
    FUNC_RESET  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FINISH,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic       absorb;
    logic       clear;
    logic       load;
    logic       round;
    logic       finish;
    logic       fin_mode;
    logic       blk;
    logic       two;
    logic [5:0] rnd;
    logic [2:0] widx;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [5:0] fill;
  } status_t;

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] v;
    case (i)
      3'd0:    v = 32'h6a09e667;
      3'd1:    v = 32'hbb67ae85;
      3'd2:    v = 32'h3c6ef372;
      3'd3:    v = 32'ha54ff53a;
      3'd4:    v = 32'h510e527f;
      3'd5:    v = 32'h9b05688c;
      3'd6:    v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_const(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

/* sv/sha256_ctrl.sv */
// Sequencer of the SHA-256 hasher: accepts bytes, runs the 64 rounds, emits the digest.
// Depends on sha256_pkg.
module sha256_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [1:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic                 m_tlast,
  input  sha256_pkg::status_t  status,
  output sha256_pkg::cmd_t     cmd
);
  import sha256_pkg::*;

  state_t     state, state_next;
  logic [5:0] rnd;
  logic [2:0] widx;
  logic       blk, fin_mode, two;
  logic       in_acc;
  func_t      func;

  assign func   = func_t'(s_tuser);
  assign in_acc = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (func == FUNC_FINAL) state_next = ST_LOAD;
          else if (func == FUNC_ABSORB && status.fill == 6'd63) state_next = ST_LOAD;
        end
      end
      ST_LOAD:  state_next = ST_ROUND;
      ST_ROUND: if (rnd == 6'd63) state_next = ST_FINISH;
      ST_FINISH: begin
        if (fin_mode && !blk && two) state_next = ST_LOAD;
        else if (fin_mode) state_next = ST_EMIT;
        else state_next = ST_IDLE;
      end
      ST_EMIT:  if (m_tready && widx == 3'd7) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.fin_mode = fin_mode;
    cmd.blk      = blk;
    cmd.two      = two;
    cmd.rnd      = rnd;
    cmd.widx     = widx;
    s_tready     = 1'b0;
    m_tvalid     = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.absorb = in_acc && func == FUNC_ABSORB;
        cmd.clear  = in_acc && func == FUNC_RESET;
      end
      ST_LOAD:   cmd.load   = 1'b1;
      ST_ROUND:  cmd.round  = 1'b1;
      ST_FINISH: cmd.finish = 1'b1;
      ST_EMIT:   m_tvalid   = 1'b1;
      default: ;
    endcase
  end

  assign m_tlast = widx == 3'd7;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rnd      <= '0;
      widx     <= '0;
      blk      <= 1'b0;
      fin_mode <= 1'b0;
      two      <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            blk      <= 1'b0;
            fin_mode <= func == FUNC_FINAL;
            two      <= status.fill >= 6'd56;
          end
        end
        ST_LOAD:  rnd <= '0;
        ST_ROUND: rnd <= rnd + 6'd1;
        ST_FINISH: begin
          if (fin_mode && !blk && two) blk <= 1'b1;
          widx <= '0;
        end
        ST_EMIT:  if (m_tready) widx <= widx + 3'd1;
        default: ;
      endcase
    end
  end

endmodule

/* sv/sha256_datapath.sv */
// SHA-256 datapath: block buffer, message schedule window, round unit, chaining words.
// Depends on sha256_pkg; driven by sha256_ctrl.
module sha256_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  sha256_pkg::cmd_t     cmd,
  input  logic [7:0]           data_byte,
  output sha256_pkg::status_t  status,
  output logic [31:0]          digest_word
);
  import sha256_pkg::*;

  logic [31:0] h_reg [8];
  logic [31:0] t_reg [8];
  logic [31:0] work  [8];
  logic [31:0] win   [16];
  logic [31:0] buf_w [16];
  logic [5:0]  fill;
  logic [63:0] count;

  logic [31:0] base [8];
  logic [31:0] raw, msg, sched, wt;
  logic [31:0] s1e, ch, s0a, maj, tmp1, tmp2;
  logic [4:0]  shamt;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // byte layout of the padded copy; p runs over both blocks
  function automatic logic [31:0] pad_word(input logic blk, input logic [3:0] t,
                                           input logic [31:0] rw, input logic [5:0] f,
                                           input logic two, input logic [63:0] bits);
    logic [6:0]  p, ls, lofs;
    logic [7:0]  b;
    logic [31:0] w;
    ls = two ? 7'd120 : 7'd56;
    w  = '0;
    for (int k = 0; k < 4; k++) begin
      p    = {blk, t, 2'(k)};
      lofs = p - ls;
      if (p < {1'b0, f}) b = rw[31-8*k -: 8];
      else if (p == {1'b0, f}) b = 8'h80;
      else if (p >= ls) b = 8'(bits >> {3'(3'd7 - lofs[2:0]), 3'b000});
      else b = 8'h00;
      w[31-8*k -: 8] = b;
    end
    return w;
  endfunction

  always_comb begin
    for (int i = 0; i < 8; i++) base[i] = (cmd.fin_mode && cmd.blk) ? t_reg[i] : h_reg[i];
  end

  assign raw   = buf_w[cmd.rnd[3:0]];
  assign msg   = cmd.fin_mode ? pad_word(cmd.blk, cmd.rnd[3:0], raw, fill, cmd.two,
                                         {count[60:0], 3'b000}) : raw;
  assign sched = win[0] + (ror(win[1], 7) ^ ror(win[1], 18) ^ (win[1] >> 3)) + win[9]
               + (ror(win[14], 17) ^ ror(win[14], 19) ^ (win[14] >> 10));
  assign wt    = (cmd.rnd < 6'd16) ? msg : sched;

  assign s1e  = ror(work[4], 6) ^ ror(work[4], 11) ^ ror(work[4], 25);
  assign ch   = (work[4] & work[5]) ^ (~work[4] & work[6]);
  assign s0a  = ror(work[0], 2) ^ ror(work[0], 13) ^ ror(work[0], 22);
  assign maj  = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
  assign tmp1 = work[7] + s1e + ch + round_const(cmd.rnd) + wt;
  assign tmp2 = s0a + maj;

  // big-endian lane within the buffer word
  assign shamt = {~fill[1:0], 3'b000};

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < 8; i++) h_reg[i] <= init_hash(3'(i));
      fill  <= '0;
      count <= '0;
    end else begin
      if (cmd.absorb) begin
        fill  <= fill + 6'd1;
        count <= count + 64'd1;
      end
      if (cmd.finish && !cmd.fin_mode) begin
        for (int i = 0; i < 8; i++) h_reg[i] <= base[i] + work[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.absorb) begin
      buf_w[fill[5:2]] <= (buf_w[fill[5:2]] & ~(32'hff << shamt))
                        | ({24'd0, data_byte} << shamt);
    end
    if (cmd.load) begin
      for (int i = 0; i < 8; i++) work[i] <= base[i];
    end
    if (cmd.round) begin
      for (int i = 0; i < 15; i++) win[i] <= win[i+1];
      win[15] <= wt;
      work[7] <= work[6];
      work[6] <= work[5];
      work[5] <= work[4];
      work[4] <= work[3] + tmp1;
      work[3] <= work[2];
      work[2] <= work[1];
      work[1] <= work[0];
      work[0] <= tmp1 + tmp2;
    end
    if (cmd.finish && cmd.fin_mode) begin
      for (int i = 0; i < 8; i++) t_reg[i] <= base[i] + work[i];
    end
  end

  assign status.fill = fill;
  assign digest_word = t_reg[cmd.widx];

endmodule

/* sv/sha256_stream_hasher.sv */
// Top level of the SHA-256 stream hasher: controller plus datapath.
// Depends on sha256_pkg, sha256_ctrl, sha256_datapath.
//
//  channel | dir | tdata                         | tuser     | tlast
//  s_      | in  | [7:0] data_byte               | [1:0] func| -
//  m_      | out | [31:0] digest_word,[34:32] idx| -         | last digest word
//
// Absorb, reset and idle codes are taken in idle. The absorb that fills the block
// holds s_tready low through load, 64 rounds of the single round unit and add.
// Finalize compresses one or two padded blocks, then eight words at m_tready pace.
// rst is synchronous; it restores the initial hash and clears the counts.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic [1:0]  s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // digest_word [31:0], word_index [34:32], zeros
  output logic        m_tlast
);
  import sha256_pkg::*;

  cmd_t        cmd;
  status_t     status;
  logic [31:0] digest_word;

  sha256_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .status   (status),
    .cmd      (cmd)
  );

  sha256_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (s_tdata),
    .status      (status),
    .digest_word (digest_word)
  );

  assign m_tdata = {5'd0, cmd.widx, digest_word};

endmodule

/* sv/sha256_checker.sv */
// Port-level checks for the SHA-256 stream hasher, bound to the top level.
// Depends on sha256_stream_hasher ports only.
module sha256_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast
);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input taken while digest words pending");

  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[34:32] == 3'd7)
    else $error("tlast not on word seven");

  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid &&
    m_tdata[34:32] == 3'($past(m_tdata[34:32]) + 3'd1))
    else $error("digest word index skipped");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled word changed");

endmodule

bind sha256_stream_hasher sha256_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
